/* hdl/mjsd_pkg.sv */
package mjsd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int KW_LEN_SIZE = 16;
   localparam int KW_TIME_SIZE = 9;
   localparam int LEN_POS_BITS = $clog2(KW_LEN_SIZE + 1);
   localparam int TIME_POS_BITS = $clog2(KW_TIME_SIZE + 1);
   localparam logic [8*KW_LEN_SIZE-1:0] KW_LEN_TEXT = "Content-length: ";
   localparam logic [8*KW_TIME_SIZE-1:0] KW_TIME_TEXT = "Current: ";

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI = 8'hD8;
   localparam logic [7:0] MARK_EOI = 8'hD9;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_C = 8'h43;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic KIND_IMAGE = 1'b0;
   localparam logic KIND_TIME = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic kind;
      logic last_of_image;
      logic image_good;
      logic [15:0] good_count;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic [7:0] kw_len_char(logic [LEN_POS_BITS-2:0] pos);
      kw_len_char = KW_LEN_TEXT[8*(KW_LEN_SIZE-1-int'(pos)) +: 8];
   endfunction

   function automatic logic [7:0] kw_time_char(logic [TIME_POS_BITS-1:0] pos);
      kw_time_char = KW_TIME_TEXT[8*(KW_TIME_SIZE-1-int'(pos)) +: 8];
   endfunction

endpackage

/* hdl/mjpeg_stream_deframer_core.sv */
// motion-jpeg multipart deframer: one stream byte is taken per clock while full is low, and
// its results are queued in a four-entry result fifo that drains one result per clock
// through pop; image bytes have rsp_kind 0, timestamp text after "Current: " has rsp_kind 1,
// the frame length comes from the decimal value after "Content-length: " (saturating, at
// least 2) and an image starts at ff d8; the start marker yields two results in one clock,
// so full rises when fewer than two fifo entries are free, and a steady stream with pop held
// high runs at one byte per clock; the results of a byte are registered in the fifo and
// reach the ports in order once the results ahead of them have been popped
module mjpeg_stream_deframer_core #(
   parameter int LENGTH_BITS = mjsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [7:0] req_in_byte,
   output logic full,
   output logic empty,
   input  logic pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_kind,
   output logic rsp_last_of_image,
   output logic rsp_image_good,
   output logic [15:0] rsp_good_count
);
   import mjsd_pkg::*;

   push_type push_bus;
   rsp_item_type head;
   logic accept;

   assign accept = push && !full;

   mjsd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .in_byte(req_in_byte),
      .push(push_bus)
   );

   mjsd_result_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_bus),
      .full(full),
      .empty(empty),
      .pop(pop),
      .head(head)
   );

   assign rsp_out_byte = head.out_byte;
   assign rsp_kind = head.kind;
   assign rsp_last_of_image = head.last_of_image;
   assign rsp_image_good = head.image_good;
   assign rsp_good_count = head.good_count;

endmodule

/* hdl/mjsd_parser.sv */
module mjsd_parser #(
   parameter int LENGTH_BITS = mjsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] in_byte,
   output mjsd_pkg::push_type push
);
   import mjsd_pkg::*;

   localparam logic [1:0] CAPTURE_NONE = 2'd0;
   localparam logic [1:0] CAPTURE_LENGTH = 2'd1;
   localparam logic [1:0] CAPTURE_TIME = 2'd2;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_MIN = LENGTH_BITS'(2);

   logic in_image_ff, in_image_in;
   logic [7:0] previous_byte_ff;
   logic [LENGTH_BITS-1:0] frame_length_ff, frame_length_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [LEN_POS_BITS-1:0] length_pos_ff, length_pos_in;
   logic [TIME_POS_BITS-1:0] time_pos_ff, time_pos_in;
   logic [1:0] capture_ff, capture_in;
   logic [15:0] tally_ff, tally_in;

   logic [LENGTH_BITS-1:0] bytes_dec;
   logic [LENGTH_BITS-1:0] len_fix;
   logic [LENGTH_BITS+3:0] acc;
   logic is_digit;
   logic tail_good;
   logic start_hit;
   logic length_hit, time_hit;
   logic [LEN_POS_BITS-1:0] length_pos_adv;
   logic [TIME_POS_BITS-1:0] time_pos_adv;
   logic restart_c;
   mjsd_pkg::push_type push_int;

   assign bytes_dec = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;
   assign len_fix = (frame_length_ff < LEN_MIN) ? LEN_MIN : frame_length_ff;
   assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign acc = {1'b0, frame_length_ff, 3'b000} + {3'b000, frame_length_ff, 1'b0}
                + (LENGTH_BITS+4)'(in_byte - CHAR_ZERO);
   assign tail_good = (previous_byte_ff == MARK_PREFIX) && (in_byte == MARK_EOI);
   assign start_hit = (previous_byte_ff == MARK_PREFIX) && (in_byte == MARK_SOI);
   assign restart_c = (in_byte == CHAR_UPPER_C);

   assign length_hit = (length_pos_ff < LEN_POS_BITS'(KW_LEN_SIZE))
                       && (kw_len_char(length_pos_ff[LEN_POS_BITS-2:0]) == in_byte);
   assign time_hit = (time_pos_ff < TIME_POS_BITS'(KW_TIME_SIZE))
                     && (kw_time_char(time_pos_ff) == in_byte);
   assign length_pos_adv = length_hit ? length_pos_ff + 1'b1 : LEN_POS_BITS'(restart_c);
   assign time_pos_adv = time_hit ? time_pos_ff + 1'b1 : TIME_POS_BITS'(restart_c);

   always_comb begin
      in_image_in = in_image_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in = bytes_left_ff;
      length_pos_in = length_pos_ff;
      time_pos_in = time_pos_ff;
      capture_in = capture_ff;
      tally_in = tally_ff;
      push_int.count = 2'd0;
      push_int.first.out_byte = in_byte;
      push_int.first.kind = KIND_IMAGE;
      push_int.first.last_of_image = 1'b0;
      push_int.first.image_good = 1'b0;
      push_int.first.good_count = tally_ff;
      push_int.second = push_int.first;
      if (in_image_ff) begin
         push_int.count = 2'd1;
         bytes_left_in = bytes_dec;
         if (bytes_dec == '0) begin
            in_image_in = 1'b0;
            push_int.first.last_of_image = 1'b1;
            if (tail_good) begin
               tally_in = tally_ff + 1'b1;
               push_int.first.image_good = 1'b1;
               push_int.first.good_count = tally_ff + 1'b1;
            end
         end
      end else if (start_hit) begin
         push_int.count = 2'd2;
         push_int.first.out_byte = MARK_PREFIX;
         push_int.second.out_byte = MARK_SOI;
         push_int.second.last_of_image = (len_fix == LEN_MIN);
         capture_in = CAPTURE_NONE;
         length_pos_in = '0;
         time_pos_in = '0;
         bytes_left_in = len_fix - LEN_MIN;
         in_image_in = (len_fix != LEN_MIN);
      end else begin
         case (capture_ff)
            CAPTURE_LENGTH: begin
               if (is_digit) begin
                  frame_length_in = (acc > {4'b0000, LEN_MAX}) ? LEN_MAX
                                                              : acc[LENGTH_BITS-1:0];
               end else begin
                  capture_in = CAPTURE_NONE;
               end
            end
            CAPTURE_TIME: begin
               if (in_byte == CHAR_CR || in_byte == CHAR_LF || in_byte == MARK_PREFIX) begin
                  capture_in = CAPTURE_NONE;
               end else begin
                  push_int.count = 2'd1;
                  push_int.first.kind = KIND_TIME;
               end
            end
            default: begin
               length_pos_in = length_pos_adv;
               time_pos_in = time_pos_adv;
               if (length_pos_adv >= LEN_POS_BITS'(KW_LEN_SIZE)) begin
                  capture_in = CAPTURE_LENGTH;
                  frame_length_in = '0;
                  length_pos_in = '0;
                  time_pos_in = '0;
               end else if (time_pos_adv >= TIME_POS_BITS'(KW_TIME_SIZE)) begin
                  capture_in = CAPTURE_TIME;
                  length_pos_in = '0;
                  time_pos_in = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      push = push_int;
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_image_ff <= 1'b0;
         previous_byte_ff <= '0;
         frame_length_ff <= '0;
         bytes_left_ff <= '0;
         length_pos_ff <= '0;
         time_pos_ff <= '0;
         capture_ff <= CAPTURE_NONE;
         tally_ff <= '0;
      end else if (accept) begin
         in_image_ff <= in_image_in;
         previous_byte_ff <= in_byte;
         frame_length_ff <= frame_length_in;
         bytes_left_ff <= bytes_left_in;
         length_pos_ff <= length_pos_in;
         time_pos_ff <= time_pos_in;
         capture_ff <= capture_in;
         tally_ff <= tally_in;
      end
   end

endmodule

/* hdl/mjsd_result_queue.sv */
module mjsd_result_queue (
   input  logic clock,
   input  logic reset,
   input  mjsd_pkg::push_type push,
   output logic full,
   output logic empty,
   input  logic pop,
   output mjsd_pkg::rsp_item_type head
);
   import mjsd_pkg::*;

   rsp_item_type mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0] count_ff, count_in;
   logic pop_ok;

   assign empty = (count_ff == '0);
   assign full = (count_ff > (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
   assign pop_ok = pop && !empty;
   assign head = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop_ok);
   assign count_in = count_ff + (QUEUE_PTR_BITS+1)'(push.count)
                     - (QUEUE_PTR_BITS+1)'(pop_ok);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[QUEUE_PTR_BITS'(wr_ptr_ff + 1'b1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* tb/sv/tb_mjpeg_stream_deframer_core.sv */
`timescale 1ns / 100ps

module tb_mjpeg_stream_deframer_core;
   import mjsd_pkg::*;

   localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
   localparam longint LEN_CEILING = (longint'(1) << LEN_BITS) - 1;
   localparam string LEN_KEYWORD = "Content-length: ";
   localparam string TIME_KEYWORD = "Current: ";
   localparam int RANDOM_BYTES = 220;
   localparam int HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {CAPT_NONE, CAPT_LENGTH, CAPT_TIME} capture_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic pop = 1'b0;
   logic full;
   logic empty;
   logic [7:0] rsp_out_byte;
   logic rsp_kind;
   logic rsp_last_of_image;
   logic rsp_image_good;
   logic [15:0] rsp_good_count;

   // deframer prediction state
   logic image_mode;
   logic [7:0] prev_byte;
   logic [LEN_BITS-1:0] stored_len;
   logic [LEN_BITS-1:0] bytes_to_go;
   logic [15:0] tail_pair;
   int len_pos;
   int time_pos;
   capture_type capture;
   logic [15:0] good_tally;
   rsp_item_type expected_results[$];

   int fail_count = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int frames_closed = 0;
   int time_results = 0;
   int input_stalls = 0;
   int quiet_cycles = 0;
   int planned_len = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_stall = 0;
   logic calm = 1'b0;

   mjpeg_stream_deframer_core u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_in_byte(req_in_byte),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_kind(rsp_kind),
      .rsp_last_of_image(rsp_last_of_image),
      .rsp_image_good(rsp_image_good),
      .rsp_good_count(rsp_good_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void queue_result(logic [7:0] value, logic kind, logic last,
                                        logic good);
      rsp_item_type item;
      item.out_byte = value;
      item.kind = kind;
      item.last_of_image = last;
      item.image_good = good;
      item.good_count = good_tally;
      expected_results.push_back(item);
   endfunction

   function automatic void deframe_image_byte(logic [7:0] value);
      logic last;
      logic good;
      last = 1'b0;
      good = 1'b0;
      tail_pair = {tail_pair[7:0], value};
      if (bytes_to_go != '0) bytes_to_go = bytes_to_go - 1'b1;
      if (bytes_to_go == '0) begin
         last = 1'b1;
         frames_closed++;
         if (tail_pair == {MARK_PREFIX, MARK_EOI}) begin
            good = 1'b1;
            good_tally = good_tally + 1'b1;
         end
         image_mode = 1'b0;
      end
      queue_result(value, KIND_IMAGE, last, good);
   endfunction

   function automatic int next_match(int pos, string keyword, logic [7:0] value);
      if (pos < keyword.len() && keyword[pos] == value) return pos + 1;
      return (value == CHAR_UPPER_C) ? 1 : 0;
   endfunction

   function automatic void predict_stream_byte(logic [7:0] value);
      longint grown;
      if (image_mode) begin
         deframe_image_byte(value);
      end else if (prev_byte == MARK_PREFIX && value == MARK_SOI) begin
         capture = CAPT_NONE;
         len_pos = 0;
         time_pos = 0;
         image_mode = 1'b1;
         tail_pair = {8'h00, MARK_PREFIX};
         bytes_to_go = ((stored_len < 2) ? LEN_BITS'(2) : stored_len) - 1'b1;
         queue_result(MARK_PREFIX, KIND_IMAGE, 1'b0, 1'b0);
         deframe_image_byte(value);
      end else if (capture == CAPT_LENGTH) begin
         if (value >= CHAR_ZERO && value <= CHAR_NINE) begin
            grown = longint'(stored_len) * 10 + longint'(value - CHAR_ZERO);
            stored_len = (grown > LEN_CEILING) ? LEN_BITS'(LEN_CEILING) : LEN_BITS'(grown);
         end else begin
            capture = CAPT_NONE;
         end
      end else if (capture == CAPT_TIME) begin
         if (value == CHAR_CR || value == CHAR_LF || value == MARK_PREFIX) begin
            capture = CAPT_NONE;
         end else begin
            queue_result(value, KIND_TIME, 1'b0, 1'b0);
            time_results++;
         end
      end else begin
         len_pos = next_match(len_pos, LEN_KEYWORD, value);
         time_pos = next_match(time_pos, TIME_KEYWORD, value);
         if (len_pos >= LEN_KEYWORD.len()) begin
            capture = CAPT_LENGTH;
            stored_len = '0;
            len_pos = 0;
            time_pos = 0;
         end else if (time_pos >= TIME_KEYWORD.len()) begin
            capture = CAPT_TIME;
            len_pos = 0;
            time_pos = 0;
         end
      end
      prev_byte = value;
   endfunction

   // monitor: predicts on each input transaction, checks each result transaction
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         image_mode = 1'b0;
         prev_byte = 8'h00;
         stored_len = '0;
         bytes_to_go = '0;
         tail_pair = 16'h0000;
         len_pos = 0;
         time_pos = 0;
         capture = CAPT_NONE;
         good_tally = 16'h0000;
         quiet_cycles = 0;
      end else begin
         if (push && !full) predict_stream_byte(req_in_byte);
         if (push && full) input_stalls++;
         if (pop && !empty) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: out_byte %0h", rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte expected %0h got %0h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_kind !== want.kind) begin
                  $error("kind expected %0d got %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_last_of_image !== want.last_of_image) begin
                  $error("last_of_image expected %0d got %0d", want.last_of_image,
                         rsp_last_of_image);
                  fail_count++;
               end
               if (rsp_image_good !== want.image_good) begin
                  $error("image_good expected %0d got %0d", want.image_good, rsp_image_good);
                  fail_count++;
               end
               if (rsp_good_count !== want.good_count) begin
                  $error("good_count expected %0d got %0d", want.good_count, rsp_good_count);
                  fail_count++;
               end
            end
         end
         quiet_cycles = ((push && !full) || (pop && !empty)) ? 0 : quiet_cycles + 1;
      end
   end

   // receiver: random stall bursts plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rx_stall = 0;
         hold_left = 0;
         hold_seen = 0;
      end else if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES - 1;
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rx_stall = $urandom_range(0, 10);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   initial begin
      @(negedge reset);
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL mjpeg_stream_deframer_core");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      if (!calm && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   // one frame from the start marker on, as many bytes as the block will count
   task automatic send_image(input int length, input bit good_tail);
      int total;
      logic [7:0] value;
      total = (length < 2) ? 2 : length;
      for (int i = 0; i < total; i++) begin
         if (i == 0) value = MARK_PREFIX;
         else if (i == 1) value = MARK_SOI;
         else if (good_tail && total >= 4 && i == total - 2) value = MARK_PREFIX;
         else if (good_tail && total >= 4 && i == total - 1) value = MARK_EOI;
         else value = 8'($urandom_range(0, 255));
         send_byte(value);
      end
   endtask

   task automatic send_random_header();
      int pick;
      logic [7:0] value;
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         send_text("Content-len\r\n");
      end else if (pick == 1) begin
         send_text({LEN_KEYWORD, "\r\n"});
         planned_len = 0;
      end else if (pick <= 13) begin
         if (pick == 2) planned_len = $urandom_range(0, 3);
         else if (pick == 3) planned_len = $urandom_range(64, 160);
         else planned_len = $urandom_range(4, 40);
         send_text({LEN_KEYWORD, $sformatf("%0d", planned_len), "\r\n"});
      end
      if ($urandom_range(0, 1) == 1) begin
         send_text(TIME_KEYWORD);
         repeat ($urandom_range(1, 8)) begin
            value = 8'($urandom_range(0, 254));
            if (value == CHAR_CR || value == CHAR_LF) value = 8'h20;
            send_byte(value);
         end
         case ($urandom_range(0, 2))
            0: send_byte(CHAR_CR);
            1: send_byte(CHAR_LF);
            default: send_byte(MARK_PREFIX);
         endcase
      end
      // broken start marker
      if ($urandom_range(0, 7) == 0) begin
         send_byte(MARK_PREFIX);
         send_byte(8'($urandom_range(0, 8'hD7)));
      end
   endtask

   task automatic test_bare_start_marker();
      send_byte(8'h00);
      send_byte(MARK_SOI);
      send_image(0, 1'b0);
      send_byte(MARK_SOI);
   endtask

   task automatic test_good_frames();
      send_text({LEN_KEYWORD, "6\r\n"});
      // markers inside image data are plain data
      send_byte(MARK_PREFIX);
      send_byte(MARK_SOI);
      send_byte(MARK_PREFIX);
      send_byte(MARK_SOI);
      send_byte(MARK_PREFIX);
      send_byte(MARK_EOI);
      send_text({LEN_KEYWORD, "3\r\n"});
      send_byte(MARK_PREFIX);
      send_byte(MARK_SOI);
      send_byte(MARK_PREFIX);
      // frame ended in ff, so d8 opens the next one
      send_byte(MARK_SOI);
      send_byte(8'h80);
   endtask

   task automatic test_short_lengths();
      send_text({LEN_KEYWORD, "1\r"});
      send_image(1, 1'b0);
      send_text({LEN_KEYWORD, "\n"});
      send_image(0, 1'b0);
      send_text({LEN_KEYWORD, "0007\r\n"});
      send_image(7, 1'b1);
   endtask

   task automatic test_timestamps();
      send_text({TIME_KEYWORD, "12:34:56\r\n"});
      send_text(TIME_KEYWORD);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFE);
      send_byte(CHAR_LF);
      // ff ends the capture and pairs with the next d8
      send_text({TIME_KEYWORD, "ab"});
      send_image(7, 1'b1);
   endtask

   task automatic test_keyword_restart();
      send_text({"C", LEN_KEYWORD, "5\r"});
      send_text({"Cu", TIME_KEYWORD, "z\n"});
      send_image(5, 1'b1);
      send_text("Conte");
      send_image(5, 1'b1);
      send_text("ngth: 9\r\n");
      send_image(5, 1'b1);
      send_text({LEN_KEYWORD, "4", TIME_KEYWORD, "x\n"});
      send_image(4, 1'b1);
   endtask

   task automatic test_length_saturation();
      send_text({LEN_KEYWORD, "99999999999\r\n"});
      send_text({LEN_KEYWORD, "2\r\n"});
      send_image(2, 1'b0);
   endtask

   task automatic test_result_backpressure();
      send_text({LEN_KEYWORD, "60\r\n"});
      hold_request <= hold_request + 1;
      send_image(60, 1'b1);
   endtask

   task automatic test_random_streams();
      int first;
      first = bytes_sent;
      while (bytes_sent - first < RANDOM_BYTES) begin
         send_random_header();
         if ($urandom_range(0, 9) != 0) send_image(planned_len, $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic test_steady_stream();
      calm <= 1'b1;
      repeat (4) begin
         send_random_header();
         send_image(planned_len, 1'b1);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_bare_start_marker();
      test_good_frames();
      test_short_lengths();
      test_timestamps();
      test_keyword_restart();
      test_length_saturation();
      test_result_backpressure();
      test_random_streams();
      test_steady_stream();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("stream bytes %0d, results checked %0d, frames closed %0d, good frames %0d",
               bytes_sent, results_checked, frames_closed, good_tally);
      $display("timestamp bytes %0d, cycles with input held off by full %0d",
               time_results, input_stalls);
      if (fail_count == 0) begin
         $display("PASS mjpeg_stream_deframer_core");
      end else begin
         $display("FAIL mjpeg_stream_deframer_core");
      end
      $finish;
   end

endmodule
